### rtl/core/ccal_pkg.sv
// Package: shared types, constants and month length function for the calendar clock.
package ccal_pkg;

  localparam int unsigned YearW    = 12;
  localparam int unsigned YearOffW = 7;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;

  localparam logic [YearW-1:0]    YEAR_MIN      = 12'd2000;
  localparam logic [YearW-1:0]    YEAR_MAX      = 12'd2099;
  localparam logic [YearOffW-1:0] YEAR_OFF_MAX  = 7'd99;
  localparam logic [YearOffW-1:0] YEAR_OFF_RST  = 7'd25;
  localparam logic [MonthW-1:0]   MONTH_MAX     = 4'd12;
  localparam logic [HourW-1:0]    HOUR_MAX      = 5'd23;
  localparam logic [MinW-1:0]     MIN_MAX       = 6'd59;
  localparam logic [SecW-1:0]     SEC_MAX       = 6'd59;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_TIME = 2'd1,
    ACT_SET_DATE = 2'd2,
    ACT_INCR     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5
  } field_e;

  // Within 2000..2099 a year is leap exactly when it is divisible by four.
  function automatic logic [DayW-1:0] days_in(input logic leap, input logic [MonthW-1:0] month);
    logic [DayW-1:0] n;
    unique case (month)
      4'd2:                         n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
      default:                      n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/ccal_intf.sv
// Interfaces: command and clock readout channels with valid/ready handshake.
interface ccal_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  field_select;
  logic [11:0] new_year;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [4:0]  new_hour;
  logic [5:0]  new_minute;
  logic [5:0]  new_second;

  modport source (output valid, action, field_select, new_year, new_month, new_day,
                  new_hour, new_minute, new_second, input ready);
  modport sink   (input valid, action, field_select, new_year, new_month, new_day,
                  new_hour, new_minute, new_second, output ready);
endinterface

interface ccal_time_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_now;
  logic [3:0]  month_now;
  logic [4:0]  day_now;
  logic [4:0]  hour_now;
  logic [5:0]  minute_now;
  logic [5:0]  second_now;
  logic        accepted;

  modport source (output valid, year_now, month_now, day_now, hour_now, minute_now,
                  second_now, accepted, input ready);
  modport sink   (input valid, year_now, month_now, day_now, hour_now, minute_now,
                  second_now, accepted, output ready);
endinterface

### rtl/core/calendar_clock_with_leap_years.sv
// Top level: calendar clock with leap years, one command in, one clock readout out.
// Each command transfer (tick, set time, set date, or field increment) produces one readout
// of the full clock after the command plus an accepted flag. Commands are taken one per cycle
// sustained while readouts are taken; each command is held in the command register, then the
// calendar update writes the clock registers and the result register together. A readout
// that is not taken holds the command register, so at most two commands are in flight before
// the input stalls. The year is held as an offset from 2000 and wraps from 2099 to 2000.
// After reset the clock reads 2025-01-01 00:00:00.
module calendar_clock_with_leap_years
  import ccal_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ccal_cmd_if.sink   in_i,
  ccal_time_if.source out_o
);

  logic                in_vld_q;
  action_e             act_q;
  logic [2:0]          sel_q;
  logic [YearW-1:0]    ny_q;
  logic [MonthW-1:0]   nmo_q;
  logic [DayW-1:0]     nd_q;
  logic [HourW-1:0]    nh_q;
  logic [MinW-1:0]     nmi_q;
  logic [SecW-1:0]     ns_q;

  logic [YearOffW-1:0] year_q, year_d;
  logic [MonthW-1:0]   month_q, month_d;
  logic [DayW-1:0]     day_q, day_d;
  logic [HourW-1:0]    hour_q, hour_d;
  logic [MinW-1:0]     min_q, min_d;
  logic [SecW-1:0]     sec_q, sec_d;
  logic                ok_d;

  logic                out_vld_q;
  logic                acc_q;
  logic [YearOffW-1:0] oyear_q;
  logic [MonthW-1:0]   omonth_q;
  logic [DayW-1:0]     oday_q;
  logic [HourW-1:0]    ohour_q;
  logic [MinW-1:0]     omin_q;
  logic [SecW-1:0]     osec_q;

  logic adv;
  logic in_xfer;

  assign adv       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign in_xfer   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q <= action_e'(in_i.action);
      sel_q <= in_i.field_select;
      ny_q  <= in_i.new_year;
      nmo_q <= in_i.new_month;
      nd_q  <= in_i.new_day;
      nh_q  <= in_i.new_hour;
      nmi_q <= in_i.new_minute;
      ns_q  <= in_i.new_second;
    end
  end

  always_comb begin
    logic                leap_cur;
    logic [DayW-1:0]     dim_cur;
    logic [YearOffW-1:0] yr_inc;
    logic [MonthW-1:0]   mo_inc;
    logic [DayW-1:0]     dim_n;
    logic [YearW-1:0]    ny_off;
    logic                date_ok;
    logic                time_ok;

    leap_cur = (year_q[1:0] == 2'b00);
    dim_cur  = days_in(leap_cur, month_q);
    yr_inc   = (year_q == YEAR_OFF_MAX) ? '0 : year_q + 7'd1;
    mo_inc   = (month_q == MONTH_MAX) ? 4'd1 : month_q + 4'd1;
    ny_off   = ny_q - YEAR_MIN;
    date_ok  = (ny_q >= YEAR_MIN) && (ny_q <= YEAR_MAX) && (nmo_q >= 4'd1) &&
               (nmo_q <= MONTH_MAX) && (nd_q >= 5'd1) &&
               (nd_q <= days_in(ny_q[1:0] == 2'b00, nmo_q));
    time_ok  = (nh_q <= HOUR_MAX) && (nmi_q <= MIN_MAX) && (ns_q <= SEC_MAX);
    dim_n    = dim_cur;

    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    ok_d    = 1'b1;

    unique case (act_q)
      ACT_TICK: begin
        sec_d = sec_q + 6'd1;
        if (sec_q == SEC_MAX) begin
          sec_d = '0;
          min_d = min_q + 6'd1;
          if (min_q == MIN_MAX) begin
            min_d  = '0;
            hour_d = hour_q + 5'd1;
            if (hour_q == HOUR_MAX) begin
              hour_d = '0;
              day_d  = day_q + 5'd1;
              if (day_q >= dim_cur) begin
                day_d   = 5'd1;
                month_d = mo_inc;
                if (month_q == MONTH_MAX) begin
                  year_d = yr_inc;
                end
              end
            end
          end
        end
      end
      ACT_SET_TIME: begin
        ok_d = time_ok;
        if (time_ok) begin
          hour_d = nh_q;
          min_d  = nmi_q;
          sec_d  = ns_q;
        end
      end
      ACT_SET_DATE: begin
        ok_d = date_ok;
        if (date_ok) begin
          year_d  = ny_off[YearOffW-1:0];
          month_d = nmo_q;
          day_d   = nd_q;
        end
      end
      ACT_INCR: begin
        unique case (sel_q)
          FLD_YEAR: begin
            year_d = yr_inc;
            dim_n  = days_in(yr_inc[1:0] == 2'b00, month_q);
            if (day_q > dim_n) day_d = dim_n;
          end
          FLD_MONTH: begin
            month_d = mo_inc;
            dim_n   = days_in(leap_cur, mo_inc);
            if (day_q > dim_n) day_d = dim_n;
          end
          FLD_DAY:    day_d  = (day_q >= dim_cur) ? 5'd1 : day_q + 5'd1;
          FLD_HOUR:   hour_d = (hour_q == HOUR_MAX) ? '0 : hour_q + 5'd1;
          FLD_MINUTE: min_d  = (min_q == MIN_MAX) ? '0 : min_q + 6'd1;
          FLD_SECOND: sec_d  = (sec_q == SEC_MAX) ? '0 : sec_q + 6'd1;
          default:    ok_d   = 1'b0;
        endcase
      end
      default: ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q    <= YEAR_OFF_RST;
      month_q   <= 4'd1;
      day_q     <= 5'd1;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        year_q  <= year_d;
        month_q <= month_d;
        day_q   <= day_d;
        hour_q  <= hour_d;
        min_q   <= min_d;
        sec_q   <= sec_d;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oyear_q  <= year_d;
      omonth_q <= month_d;
      oday_q   <= day_d;
      ohour_q  <= hour_d;
      omin_q   <= min_d;
      osec_q   <= sec_d;
      acc_q    <= ok_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.year_now   = YEAR_MIN + {{(YearW-YearOffW){1'b0}}, oyear_q};
  assign out_o.month_now  = omonth_q;
  assign out_o.day_now    = oday_q;
  assign out_o.hour_now   = ohour_q;
  assign out_o.minute_now = omin_q;
  assign out_o.second_now = osec_q;
  assign out_o.accepted   = acc_q;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q <= HOUR_MAX) && (min_q <= MIN_MAX) && (sec_q <= SEC_MAX) &&
    (year_q <= YEAR_OFF_MAX))
    else $error("clock register out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= 4'd1) && (month_q <= MONTH_MAX) && (day_q >= 5'd1) &&
    (day_q <= days_in(year_q[1:0] == 2'b00, month_q)))
    else $error("date register out of range");

  a_adv_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("command advanced without a readout");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !ok_d) |=> ($stable(year_q) && $stable(month_q) && $stable(day_q) &&
                        $stable(hour_q) && $stable(min_q) && $stable(sec_q) && !acc_q))
    else $error("rejected command changed the clock");

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (oyear_q == year_q) && (oday_q == day_q) && (osec_q == sec_q))
    else $error("readout differs from clock registers");

endmodule

### dv/tb_calendar_clock_with_leap_years.sv
// Testbench for the calendar clock: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb_calendar_clock_with_leap_years;
  import ccal_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] FLD_UNUSED_LO = 3'd6;
  localparam logic [2:0] FLD_UNUSED_HI = 3'd7;

  typedef struct packed {
    action_e           action;
    logic [2:0]        field_select;
    logic [YearW-1:0]  new_year;
    logic [MonthW-1:0] new_month;
    logic [DayW-1:0]   new_day;
    logic [HourW-1:0]  new_hour;
    logic [MinW-1:0]   new_minute;
    logic [SecW-1:0]   new_second;
  } command_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic              accepted;
  } readout_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ccal_cmd_if  cmd_if ();
  ccal_time_if time_if ();

  calendar_clock_with_leap_years uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (time_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [YearW-1:0]  cal_year = 12'd2025;
  logic [MonthW-1:0] cal_month = 4'd1;
  logic [DayW-1:0]   cal_day = 5'd1;
  logic [HourW-1:0]  cal_hour = '0;
  logic [MinW-1:0]   cal_minute = '0;
  logic [SecW-1:0]   cal_second = '0;

  readout_t pending_readouts[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int readouts_checked;
  int rejected_cmds;
  int cmds_by_action[4];
  int quiet_cycles;
  int hold_left;
  logic hold_req;
  logic hold_ack;

  function automatic bit leap_year(logic [YearW-1:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [DayW-1:0] month_length(logic [YearW-1:0] y, logic [MonthW-1:0] m);
    case (m)
      4'd2:                    return leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  function automatic logic [YearW-1:0] next_year(logic [YearW-1:0] y);
    return (y >= YEAR_MAX) ? YEAR_MIN : y + 1'b1;
  endfunction

  function automatic void clamp_day();
    if (cal_day > month_length(cal_year, cal_month)) cal_day = month_length(cal_year, cal_month);
  endfunction

  function automatic readout_t advance_calendar(command_t c);
    readout_t r;
    logic ok;
    ok = 1'b0;
    case (c.action)
      ACT_TICK: begin
        ok = 1'b1;
        if (cal_second < SEC_MAX) begin
          cal_second = cal_second + 1'b1;
        end else begin
          cal_second = '0;
          if (cal_minute < MIN_MAX) begin
            cal_minute = cal_minute + 1'b1;
          end else begin
            cal_minute = '0;
            if (cal_hour < HOUR_MAX) begin
              cal_hour = cal_hour + 1'b1;
            end else begin
              cal_hour = '0;
              if (cal_day < month_length(cal_year, cal_month)) begin
                cal_day = cal_day + 1'b1;
              end else begin
                cal_day = 5'd1;
                if (cal_month < MONTH_MAX) begin
                  cal_month = cal_month + 1'b1;
                end else begin
                  cal_month = 4'd1;
                  cal_year = next_year(cal_year);
                end
              end
            end
          end
        end
      end
      ACT_SET_TIME: begin
        if (c.new_hour <= HOUR_MAX && c.new_minute <= MIN_MAX && c.new_second <= SEC_MAX) begin
          cal_hour = c.new_hour;
          cal_minute = c.new_minute;
          cal_second = c.new_second;
          ok = 1'b1;
        end
      end
      ACT_SET_DATE: begin
        if (c.new_year >= YEAR_MIN && c.new_year <= YEAR_MAX &&
            c.new_month >= 4'd1 && c.new_month <= MONTH_MAX && c.new_day >= 5'd1 &&
            c.new_day <= month_length(c.new_year, c.new_month)) begin
          cal_year = c.new_year;
          cal_month = c.new_month;
          cal_day = c.new_day;
          ok = 1'b1;
        end
      end
      default: begin
        ok = 1'b1;
        case (c.field_select)
          FLD_YEAR: begin
            cal_year = next_year(cal_year);
            clamp_day();
          end
          FLD_MONTH: begin
            cal_month = (cal_month >= MONTH_MAX) ? 4'd1 : cal_month + 1'b1;
            clamp_day();
          end
          FLD_DAY: cal_day = (cal_day >= month_length(cal_year, cal_month)) ? 5'd1 : cal_day + 1'b1;
          FLD_HOUR: cal_hour = (cal_hour >= HOUR_MAX) ? '0 : cal_hour + 1'b1;
          FLD_MINUTE: cal_minute = (cal_minute >= MIN_MAX) ? '0 : cal_minute + 1'b1;
          FLD_SECOND: cal_second = (cal_second >= SEC_MAX) ? '0 : cal_second + 1'b1;
          default: ok = 1'b0;
        endcase
      end
    endcase
    r.year = cal_year;
    r.month = cal_month;
    r.day = cal_day;
    r.hour = cal_hour;
    r.minute = cal_minute;
    r.second = cal_second;
    r.accepted = ok;
    return r;
  endfunction

  function automatic command_t make_noise();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(command_t)-1:0];
  endfunction

  function automatic command_t make_tick();
    command_t c;
    c = make_noise();
    c.action = ACT_TICK;
    return c;
  endfunction

  function automatic command_t make_set_time(int h, int mi, int s);
    command_t c;
    c = make_noise();
    c.action = ACT_SET_TIME;
    c.new_hour = HourW'(h);
    c.new_minute = MinW'(mi);
    c.new_second = SecW'(s);
    return c;
  endfunction

  function automatic command_t make_set_date(int y, int m, int d);
    command_t c;
    c = make_noise();
    c.action = ACT_SET_DATE;
    c.new_year = YearW'(y);
    c.new_month = MonthW'(m);
    c.new_day = DayW'(d);
    return c;
  endfunction

  function automatic command_t make_incr(logic [2:0] sel);
    command_t c;
    c = make_noise();
    c.action = ACT_INCR;
    c.field_select = sel;
    return c;
  endfunction

  task automatic send_command(command_t c);
    readout_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.action <= c.action;
    cmd_if.field_select <= c.field_select;
    cmd_if.new_year <= c.new_year;
    cmd_if.new_month <= c.new_month;
    cmd_if.new_day <= c.new_day;
    cmd_if.new_hour <= c.new_hour;
    cmd_if.new_minute <= c.new_minute;
    cmd_if.new_second <= c.new_second;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    r = advance_calendar(c);
    pending_readouts.push_back(r);
    cmds_by_action[c.action]++;
    if (!r.accepted) rejected_cmds++;
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    readout_t exp_r;
    if (rst_ni && time_if.valid && time_if.ready) begin
      if (pending_readouts.size() == 0) begin
        $error("readout with no command outstanding");
        mismatches++;
      end else begin
        exp_r = pending_readouts.pop_front();
        check_field("year_now", exp_r.year, time_if.year_now);
        check_field("month_now", exp_r.month, time_if.month_now);
        check_field("day_now", exp_r.day, time_if.day_now);
        check_field("hour_now", exp_r.hour, time_if.hour_now);
        check_field("minute_now", exp_r.minute, time_if.minute_now);
        check_field("second_now", exp_r.second, time_if.second_now);
        check_field("accepted", exp_r.accepted, time_if.accepted);
        readouts_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      time_if.ready <= 1'b0;
      hold_left <= 0;
      hold_ack <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      time_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      time_if.ready <= 1'b0;
    end else begin
      time_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (time_if.valid && time_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[calendar_clock_with_leap_years] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_rollover();
    send_command(make_set_date(2099, 12, 31));
    send_command(make_set_time(23, 59, 59));
    send_command(make_tick());
    send_command(make_set_date(2000, 2, 29));
    send_command(make_set_time(23, 59, 59));
    send_command(make_tick());
  endtask

  task automatic test_date_checks();
    send_command(make_set_date(2100, 1, 1));
    send_command(make_set_date(4095, 15, 31));
    send_command(make_set_date(0, 0, 0));
    send_command(make_set_date(2001, 2, 29));
    send_command(make_set_date(2024, 2, 29));
  endtask

  task automatic test_time_checks();
    send_command(make_set_time(31, 63, 63));
    send_command(make_set_time(24, 59, 59));
    send_command(make_set_time(23, 59, 60));
    send_command(make_set_time(23, 59, 59));
  endtask

  task automatic test_increments();
    send_command(make_incr(FLD_YEAR));
    send_command(make_set_date(2024, 1, 31));
    send_command(make_incr(FLD_MONTH));
    send_command(make_incr(FLD_DAY));
    send_command(make_incr(FLD_HOUR));
    send_command(make_incr(FLD_MINUTE));
    send_command(make_incr(FLD_SECOND));
    send_command(make_incr(FLD_UNUSED_LO));
    send_command(make_incr(FLD_UNUSED_HI));
    send_command(make_set_date(2099, 12, 31));
    send_command(make_incr(FLD_MONTH));
    send_command(make_incr(FLD_YEAR));
  endtask

  task automatic send_random_command();
    int pick;
    int y;
    int m;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_command(make_tick());
    end else if (pick < 50) begin
      if ($urandom_range(99) < 80)
        send_command(make_set_time($urandom_range(0, 23), $urandom_range(0, 59),
                                   $urandom_range(0, 59)));
      else
        send_command(make_set_time($urandom_range(0, 31), $urandom_range(0, 63),
                                   $urandom_range(0, 63)));
    end else if (pick < 70) begin
      y = $urandom_range(2000, 2099);
      m = $urandom_range(1, 12);
      if ($urandom_range(99) < 75)
        send_command(make_set_date(y, m, $urandom_range(99) < 50 ?
                                   month_length(YearW'(y), MonthW'(m)) :
                                   $urandom_range(1, month_length(YearW'(y), MonthW'(m)))));
      else
        send_command(make_set_date($urandom_range(0, 4095), $urandom_range(0, 15),
                                   $urandom_range(0, 31)));
    end else begin
      send_command(make_incr(3'($urandom_range(0, 7))));
    end
  endtask

  task automatic test_random_mix(int n_items);
    int sent;
    int y;
    int m;
    int n_ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        y = $urandom_range(2000, 2099);
        m = $urandom_range(1, 12);
        n_ticks = $urandom_range(1, 12);
        send_command(make_set_date(y, m, month_length(YearW'(y), MonthW'(m))));
        send_command(make_set_time(23, 59, $urandom_range(50, 59)));
        repeat (n_ticks) send_command(make_tick());
        sent += 2 + n_ticks;
      end else if ($urandom_range(99) < 5) begin
        send_command(make_noise());
        sent++;
      end else begin
        send_random_command();
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req <= ~hold_req;
    repeat (40) send_random_command();
  endtask

  initial begin
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_TICK;
    cmd_if.field_select = '0;
    cmd_if.new_year = '0;
    cmd_if.new_month = '0;
    cmd_if.new_day = '0;
    cmd_if.new_hour = '0;
    cmd_if.new_minute = '0;
    cmd_if.new_second = '0;
    hold_req = 1'b0;
    mismatches = 0;
    readouts_checked = 0;
    rejected_cmds = 0;
    send_idle_pct = 26;
    recv_idle_pct = 81;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rollover();
    test_date_checks();
    test_time_checks();
    test_increments();
    test_random_mix(350);

    send_idle_pct = 81;
    recv_idle_pct = 26;
    test_random_mix(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_mix(330);

    cmd_if.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d ticks, %0d time sets, %0d date sets, %0d field steps (%0d rejected);",
             cmds_by_action[ACT_TICK], cmds_by_action[ACT_SET_TIME],
             cmds_by_action[ACT_SET_DATE], cmds_by_action[ACT_INCR], rejected_cmds);
    $display("%0d readouts checked under idling on both sides and a long readout hold.",
             readouts_checked);
    if (mismatches == 0) begin
      $display("[calendar_clock_with_leap_years] OK");
    end else begin
      $display("[calendar_clock_with_leap_years] ERROR");
    end
    $finish;
  end

endmodule
